// ===== design/gcf_pkg.sv =====
// gcf_pkg: shared types, codes and character constants of the g-code line framer
// depends on nothing; imported by every module of the block
package gcf_pkg;

  // longest line, header included, plus one for the checksum rule
  localparam int LineMax  = 128;
  localparam int LenW     = $clog2(LineMax);
  localparam logic [LenW-1:0] LenKeep = LenW'(LineMax - 1);

  // line number kept as packed bcd digits, least significant digit at index 0
  localparam int LnDigits = 10;
  localparam int DigW     = 4;
  localparam int IdxW     = $clog2(LnDigits);
  localparam logic [LnDigits*DigW-1:0] LnWrapBcd = 40'h4294967295;

  // func codes of an input item
  localparam logic [1:0] FUNC_LINE = 2'd0;
  localparam logic [1:0] FUNC_RAW  = 2'd1;
  localparam logic [1:0] FUNC_ZERO = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // characters
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last_byte;
  } gcf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } gcf_out_t;

  typedef enum logic [1:0] {
    KIND_LINE,
    KIND_RAW,
    KIND_ZERO
  } gcf_kind_e;

  typedef struct packed {
    gcf_kind_e  kind;
    logic [7:0] data_byte;
    logic       last_byte;
  } gcf_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR_N,
    ST_HDR_DIG,
    ST_HDR_SP,
    ST_CHAR,
    ST_STAR,
    ST_CS_DIG,
    ST_NL,
    ST_RAW_CHAR,
    ST_RAW_NL
  } gcf_state_e;

endpackage

// ===== design/gcf_front.sv =====
// gcf_front: input side, classifies items and holds them in a two-entry command queue
// depends on gcf_pkg
module gcf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  gcf_pkg::gcf_in_t  in_i,
  output logic              cmd_valid_o,
  output gcf_pkg::gcf_cmd_t cmd_o,
  input  logic              cmd_pop_i
);
  import gcf_pkg::*;

  gcf_cmd_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  gcf_cmd_t   cmd_new;
  logic       enq, deq;

  always_comb begin
    cmd_new.data_byte = in_i.data_byte;
    cmd_new.last_byte = in_i.last_byte;
    unique case (in_i.func)
      FUNC_LINE: cmd_new.kind = KIND_LINE;
      FUNC_RAW:  cmd_new.kind = KIND_RAW;
      FUNC_ZERO: cmd_new.kind = KIND_ZERO;
      default:   cmd_new.kind = KIND_LINE;
    endcase
  end

  assign full        = (count_q == 2'd2);
  // unused func code is taken and dropped here
  assign enq         = push && !full && (in_i.func != FUNC_NONE);
  assign deq         = cmd_pop_i && (count_q != 2'd0);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = enq ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? !rd_ptr_q : rd_ptr_q;
    count_d  = 2'(count_q + {1'b0, enq} - {1'b0, deq});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  // the fill count rises by one on an enqueue with no dequeue
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enq && !deq) |=> (count_q == 2'($past(count_q) + 2'd1)))
    else $error("queue count lost an enqueue");

endmodule

// ===== design/gcf_back.sv =====
// gcf_back: sequencer that frames lines and emits one character per transfer
// depends on gcf_pkg; holds line number (bcd), running xor, line length, open-line flag
module gcf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  gcf_pkg::gcf_cmd_t cmd_i,
  output logic              cmd_pop_o,
  output logic              emit_valid_o,
  output gcf_pkg::gcf_out_t emit_o,
  input  logic              emit_ready_i
);
  import gcf_pkg::*;

  typedef logic [LnDigits-1:0][DigW-1:0] bcd_t;
  typedef logic [2:0][DigW-1:0]          cs_t;

  gcf_state_e     state_q, state_d;
  gcf_cmd_t       cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  bcd_t           ln_q, ln_d;
  logic [7:0]     xor_q, xor_d;
  logic [LenW-1:0] len_q, len_d;
  logic           mid_q, mid_d;

  logic [IdxW-1:0] hdr_ndig;
  cs_t            cs_dig;
  logic [1:0]     cs_ndig;
  logic           keep;
  logic           fire;

  function automatic logic [IdxW-1:0] bcd_ndig(bcd_t v);
    logic [IdxW-1:0] n;
    n = IdxW'(1);
    for (int i = 0; i < LnDigits; i++) begin
      if (v[i] != '0) n = IdxW'(i + 1);
    end
    return n;
  endfunction

  function automatic bcd_t bcd_inc(bcd_t v);
    bcd_t r;
    logic carry;
    carry = 1'b1;
    for (int i = 0; i < LnDigits; i++) begin
      if (carry) r[i] = (v[i] == DigW'(9)) ? '0 : DigW'(v[i] + DigW'(1));
      else       r[i] = v[i];
      carry = carry && (v[i] == DigW'(9));
    end
    if (v == LnWrapBcd) r = '0;
    return r;
  endfunction

  function automatic cs_t cs_split(logic [7:0] x);
    cs_t        d;
    logic [1:0] h;
    logic [6:0] r;
    logic [14:0] p;
    logic [3:0] t;
    h = (x >= 8'd200) ? 2'd2 : ((x >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(x - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0)));
    // r below 100: r / 10 by reciprocal 205 / 2048
    p = 15'(r) * 15'd205;
    t = p[14:11];
    d[2] = {2'b00, h};
    d[1] = t;
    d[0] = 4'(r - 7'(t) * 7'd10);
    return d;
  endfunction

  assign hdr_ndig = bcd_ndig(ln_q);
  assign cs_dig   = cs_split(xor_q);
  assign cs_ndig  = (cs_dig[2] != '0) ? 2'd3 : ((cs_dig[1] != '0) ? 2'd2 : 2'd1);
  assign keep     = (len_q < LenKeep);
  assign fire     = emit_valid_o && emit_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    idx_d         = idx_q;
    ln_d          = ln_q;
    xor_d         = xor_q;
    len_d         = len_q;
    mid_d         = mid_q;
    cmd_pop_o     = 1'b0;
    emit_valid_o  = 1'b0;
    emit_o        = '{out_byte: CH_NL, run_end: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          unique case (cmd_i.kind)
            KIND_ZERO: ln_d = '0;
            KIND_RAW:  state_d = ST_RAW_CHAR;
            KIND_LINE: begin
              if (!mid_q) begin
                state_d = ST_HDR_N;
                xor_d   = '0;
                len_d   = '0;
                mid_d   = 1'b1;
                idx_d   = IdxW'(hdr_ndig - IdxW'(1));
              end else begin
                state_d = ST_CHAR;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HDR_N: begin
        emit_valid_o = 1'b1;
        emit_o.out_byte = CH_N;
        if (fire) state_d = ST_HDR_DIG;
      end
      ST_HDR_DIG: begin
        emit_valid_o = 1'b1;
        emit_o.out_byte = CH_ZERO | {4'b0000, ln_q[idx_q]};
        if (fire) begin
          if (idx_q == '0) state_d = ST_HDR_SP;
          else             idx_d = IdxW'(idx_q - IdxW'(1));
        end
      end
      ST_HDR_SP: begin
        emit_valid_o = 1'b1;
        emit_o.out_byte = CH_SP;
        if (fire) state_d = ST_CHAR;
      end
      ST_CHAR: begin
        // a dropped character emits nothing but still closes the line when marked last
        emit_valid_o   = keep;
        emit_o.out_byte = cmd_q.data_byte;
        emit_o.run_end  = !cmd_q.last_byte;
        if (fire || !keep) state_d = cmd_q.last_byte ? ST_STAR : ST_IDLE;
      end
      ST_STAR: begin
        emit_valid_o = 1'b1;
        emit_o.out_byte = CH_STAR;
        if (fire) begin
          state_d = ST_CS_DIG;
          idx_d   = IdxW'(cs_ndig - 2'd1);
        end
      end
      ST_CS_DIG: begin
        emit_valid_o = 1'b1;
        emit_o.out_byte = CH_ZERO | {4'b0000, cs_dig[idx_q[1:0]]};
        if (fire) begin
          if (idx_q == '0) state_d = ST_NL;
          else             idx_d = IdxW'(idx_q - IdxW'(1));
        end
      end
      ST_NL: begin
        emit_valid_o = 1'b1;
        emit_o.out_byte = CH_NL;
        emit_o.run_end  = 1'b1;
        if (fire) begin
          state_d = ST_IDLE;
          ln_d    = bcd_inc(ln_q);
          mid_d   = 1'b0;
        end
      end
      ST_RAW_CHAR: begin
        emit_valid_o = 1'b1;
        emit_o.out_byte = cmd_q.data_byte;
        emit_o.run_end  = !cmd_q.last_byte;
        if (fire) state_d = cmd_q.last_byte ? ST_RAW_NL : ST_IDLE;
      end
      ST_RAW_NL: begin
        emit_valid_o = 1'b1;
        emit_o.out_byte = CH_NL;
        emit_o.run_end  = 1'b1;
        if (fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // header and kept characters count into the open line
    if (fire && (state_q == ST_HDR_N || state_q == ST_HDR_DIG || state_q == ST_HDR_SP ||
                 state_q == ST_CHAR)) begin
      xor_d = xor_q ^ emit_o.out_byte;
      len_d = LenW'(len_q + LenW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ln_q    <= '0;
      xor_q   <= '0;
      len_q   <= '0;
      mid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ln_q    <= ln_d;
      xor_q   <= xor_d;
      len_q   <= len_d;
      mid_q   <= mid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
  end

  // a line closes only with its newline
  a_mid_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(mid_q) |-> $past(state_q == ST_NL))
    else $error("open line closed outside the trailer");

  // header states run only inside an open line
  a_hdr_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HDR_N || state_q == ST_HDR_DIG || state_q == ST_HDR_SP) |-> mid_q)
    else $error("header emitted with no open line");

  // a stalled character holds until transferred
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && !emit_ready_i) |=> (emit_valid_o && $stable(emit_o)))
    else $error("stalled character changed");

endmodule

// ===== design/gcf_outq.sv =====
// gcf_outq: one-entry output register between the sequencer and the result queue ports
// depends on gcf_pkg
module gcf_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  gcf_pkg::gcf_out_t in_i,
  output logic              in_ready_o,
  output logic              empty,
  input  logic              pop,
  output gcf_pkg::gcf_out_t out_o
);
  import gcf_pkg::*;

  logic     valid_q, valid_d;
  gcf_out_t data_q;
  logic     load;

  assign in_ready_o = !valid_q || pop;
  assign load       = in_valid_i && in_ready_o;
  assign empty      = !valid_q;
  assign out_o      = data_q;

  always_comb begin
    if (load)     valid_d = 1'b1;
    else if (pop) valid_d = 1'b0;
    else          valid_d = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_i;
    end
  end

endmodule

// ===== design/gcode_line_framer_core.sv =====
// gcode_line_framer_core: top level of the g-code line framer
// depends on gcf_pkg, gcf_front, gcf_back, gcf_outq
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  command  | in        | push / full          | in_i  : func, data_byte, last_byte
//  output   | out       | empty / pop          | out_o : out_byte, run_end
//
// sequencer steps: a mid-line character is fetched in idle, then emitted;
//   a line's first character is preceded by the header (N, line-number digits, space),
//   a closing character is followed by the trailer (star, checksum digits, newline)
// a line-number reset command is taken in the idle state and emits nothing
// the sequencer emits at most one character per cycle, set by the output register
// reset clears the queues, the line number and the open-line state at once
// a stall on pop backs up the output register, then the sequencer, then the
//   two-entry command queue, and finally raises full

module gcode_line_framer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  gcf_pkg::gcf_in_t  in_i,
  output logic              empty,
  input  logic              pop,
  output gcf_pkg::gcf_out_t out_o
);
  import gcf_pkg::*;

  // front to back command transfer
  logic     cmd_valid;
  gcf_cmd_t cmd;
  logic     cmd_pop;

  // back to output register character transfer
  logic     emit_valid;
  gcf_out_t emit;
  logic     emit_ready;

  // accepts and classifies items, drops the unused func code
  gcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // frames lines: header, kept characters, checksum trailer, raw pass-through
  gcf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .emit_ready_i (emit_ready)
  );

  // result register facing the output queue ports
  gcf_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (emit_valid),
    .in_i       (emit),
    .in_ready_o (emit_ready),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_o)
  );

endmodule
